// ===== hdl/delimited_line_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// delimited_line_tokenizer_defines
// Assertion macros shared by the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_LINE_TOKENIZER_DEFINES_SVH
`define DELIMITED_LINE_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dlt_pkg.sv =====
// ----------------------------------------------------------------------------
// dlt_pkg
// Types, codes and constants of the delimited line tokenizer.
// ----------------------------------------------------------------------------
package dlt_pkg;

  localparam int unsigned TokenBufferSize = 256;
  localparam int unsigned TokenCap =
    (TokenBufferSize - 1 > 255) ? 255 : TokenBufferSize - 1;
  localparam int unsigned ResultDepth = 4;

  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChLf         = 8'h0A;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChFirstPrint = 8'h21;
  localparam logic [7:0] PrintSpan    = 8'd94;
  localparam logic [7:0] DelimReset   = 8'h20;

  typedef enum logic [1:0] {
    OpData     = 2'd0,
    OpNextLine = 2'd1,
    OpFlush    = 2'd2,
    OpRsvd     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KindChar    = 3'd0,
    KindTokEnd  = 3'd1,
    KindLineEnd = 3'd2,
    KindSilent  = 3'd3,
    KindReject  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    SkipNone   = 3'b001,
    SkipSeek   = 3'b010,
    SkipAbsorb = 3'b100
  } skip_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] char_value;
    logic [7:0] token_length;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       line_held;
    logic       pair_pending;
    logic       last_lf;
    logic       seen_printable;
    logic       space_pending;
    logic [7:0] chars_in_token;
    skip_e      skip_phase;
  } tok_state_t;

  function automatic out_item_t mk_res(kind_e kind, logic [7:0] ch, logic [7:0] len);
    out_item_t r;
    r.result_kind  = kind;
    r.char_value   = ch;
    r.token_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/dlt_result_fifo.sv =====
// ----------------------------------------------------------------------------
// dlt_result_fifo
// Result queue: takes one or two results per cycle, delivers one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module dlt_result_fifo import dlt_pkg::*; #(
  parameter int unsigned Depth = ResultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic      push_two_i,
  input  out_item_t data0_i,
  input  out_item_t data1_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned PtrW = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wp1, wp2;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;
  logic [CntW-1:0]     push_n;

  function automatic logic [PtrW-1:0] inc_ptr(logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) return '0;
    return p + PtrW'(1);
  endfunction

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign pop         = out_valid_o && out_ready_i;
  assign wp1         = inc_ptr(wr_ptr_q);
  assign wp2         = inc_ptr(wp1);
  assign push_n      = !push_i ? CntW'(0) : (push_two_i ? CntW'(2) : CntW'(1));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = push_two_i ? wp2 : wp1;
    end
    if (pop) begin
      rd_ptr_d = inc_ptr(rd_ptr_q);
    end
    cnt_d = cnt_q + push_n - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_i && push_two_i) begin
      mem_q[wp1] <= data1_i;
    end
  end

endmodule

// ===== hdl/dlt_step.sv =====
// ----------------------------------------------------------------------------
// dlt_step
// Next-state and result logic for one registered request.
// ----------------------------------------------------------------------------
module dlt_step import dlt_pkg::*; (
  input  in_item_t   item_i,
  input  logic [7:0] delim_i,
  input  tok_state_t state_i,
  output tok_state_t state_o,
  output out_item_t  res0_o,
  output out_item_t  res1_o,
  output logic       two_o
);

  tok_state_t s;
  out_item_t  res [2];
  logic [1:0] n;
  logic       handled;
  logic [7:0] b;
  logic       is_term, is_lf, is_print;

  assign b        = item_i.byte_value;
  assign is_term  = (b == ChCr) || (b == ChLf);
  assign is_lf    = (b == ChLf);
  assign is_print = 8'(b - ChFirstPrint) < PrintSpan;

  always_comb begin
    s       = state_i;
    n       = 2'd0;
    handled = 1'b0;
    res[0]  = '0;
    res[1]  = '0;
    case (op_e'(item_i.opcode))
      OpData: begin
        unique case (s.skip_phase)
          SkipSeek: begin
            if (is_term) begin
              s.skip_phase = SkipAbsorb;
              s.last_lf    = is_lf;
            end
            handled = 1'b1;
          end
          SkipAbsorb: begin
            if (is_term) begin
              if (is_lf != s.last_lf) s.skip_phase = SkipNone;
              handled = 1'b1;
            end else begin
              s.skip_phase = SkipNone;
            end
          end
          default: ;
        endcase
        if (!handled && s.pair_pending) begin
          s.pair_pending = 1'b0;
          if (is_term && (is_lf != s.last_lf)) handled = 1'b1;
        end
        if (!handled) begin
          if (s.line_held) begin
            res[n[0]] = mk_res(KindReject, '0, '0);
            n = n + 2'd1;
          end else if (b == delim_i && (delim_i != ChSpace || s.seen_printable)) begin
            res[n[0]] = mk_res(KindTokEnd, '0, s.chars_in_token);
            n = n + 2'd1;
            s.seen_printable = 1'b0;
            s.space_pending  = 1'b0;
            s.chars_in_token = '0;
          end else if (b == ChSpace) begin
            if (s.seen_printable) s.space_pending = 1'b1;
          end else if (is_term) begin
            if (s.seen_printable) begin
              res[n[0]] = mk_res(KindTokEnd, '0, s.chars_in_token);
              n = n + 2'd1;
            end
            s.seen_printable = 1'b0;
            s.space_pending  = 1'b0;
            s.chars_in_token = '0;
            res[n[0]] = mk_res(KindLineEnd, '0, '0);
            n = n + 2'd1;
            s.line_held    = 1'b1;
            s.pair_pending = 1'b1;
            s.last_lf      = is_lf;
          end else if (is_print) begin
            s.seen_printable = 1'b1;
            if (s.space_pending) begin
              if (({1'b0, s.chars_in_token} + 9'd2) <= 9'(TokenCap)) begin
                res[0] = mk_res(KindChar, ChSpace, '0);
                res[1] = mk_res(KindChar, b, '0);
                n = 2'd2;
                s.chars_in_token = s.chars_in_token + 8'd2;
                s.space_pending  = 1'b0;
              end
            end else if ({1'b0, s.chars_in_token} < 9'(TokenCap)) begin
              res[n[0]] = mk_res(KindChar, b, '0);
              n = n + 2'd1;
              s.chars_in_token = s.chars_in_token + 8'd1;
            end
          end
        end
      end
      OpNextLine: begin
        if (s.line_held) begin
          s.line_held = 1'b0;
        end else if (s.skip_phase == SkipNone) begin
          if (s.seen_printable) begin
            res[n[0]] = mk_res(KindTokEnd, '0, s.chars_in_token);
            n = n + 2'd1;
          end
          s.seen_printable = 1'b0;
          s.space_pending  = 1'b0;
          s.chars_in_token = '0;
          s.pair_pending   = 1'b0;
          s.skip_phase     = SkipSeek;
        end else if (s.skip_phase == SkipAbsorb) begin
          s.skip_phase = SkipSeek;
        end
      end
      OpFlush: begin
        if (s.seen_printable) begin
          res[n[0]] = mk_res(KindTokEnd, '0, s.chars_in_token);
          n = n + 2'd1;
        end
        s.seen_printable = 1'b0;
        s.space_pending  = 1'b0;
        s.chars_in_token = '0;
        s.pair_pending   = 1'b0;
        s.skip_phase     = SkipNone;
      end
      default: ;
    endcase
    if (n == 2'd0) begin
      res[0] = mk_res(KindSilent, '0, '0);
      n = 2'd1;
    end
    if (n[1]) begin
      res[1].last_of_run = 1'b1;
    end else begin
      res[0].last_of_run = 1'b1;
    end
  end

  assign state_o = s;
  assign res0_o  = res[0];
  assign res1_o  = res[1];
  assign two_o   = n[1];

endmodule

// ===== hdl/delimited_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// delimited_line_tokenizer
// Splits a byte stream into token characters, token ends and line ends.
// ----------------------------------------------------------------------------
//  channel  direction  payload     handshake
//  in       input      in_item_t   in_valid_i / in_ready_o
//  out      output     out_item_t  out_valid_o / out_ready_i
//  cfg      input      delimiter   cfg_valid_i / cfg_ready_o
//
//  A request is registered, then stepped combinationally into one or two results.
//  One request per cycle is taken while the output queue has room; the two results
//  of a request leave one after the other through the one-result-per-cycle queue.
//  Between input and output lie the request register and the output queue.
//  Reset clears the tokenizer state and sets the delimiter to space.
//  An output queue without room for two results stalls the input register, which then drops in_ready_o.
// ----------------------------------------------------------------------------
module delimited_line_tokenizer import dlt_pkg::*; #(
  parameter int unsigned ResDepth = ResultDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic       in_vld_q;
  in_item_t   in_q;
  logic [7:0] delim_q;
  tok_state_t st_q, st_d;
  out_item_t  res0, res1;
  logic       two, room, step_fire;

  assign step_fire   = in_vld_q && room;
  assign in_ready_o  = !in_vld_q || step_fire;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      delim_q  <= DelimReset;
      st_q     <= '{skip_phase: SkipNone, default: '0};
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (cfg_valid_i) delim_q <= cfg_data_i;
      if (step_fire) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  dlt_step u_step (
    .item_i  (in_q),
    .delim_i (delim_q),
    .state_i (st_q),
    .state_o (st_d),
    .res0_o  (res0),
    .res1_o  (res1),
    .two_o   (two)
  );

  dlt_result_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step_fire),
    .push_two_i  (two),
    .data0_i     (res0),
    .data1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/dlt_checker.sv =====
// ----------------------------------------------------------------------------
// dlt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "delimited_line_tokenizer_defines.svh"

module dlt_checker import dlt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input out_item_t  out_data_o
);

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  `DLT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "out request changed while stalled")
  `DLT_ASSERT_NOW(a_kind_range, out_valid_o, out_data_o.result_kind <= KindReject, "result kind out of range")
  `DLT_ASSERT_NOW(a_line_end_last, out_valid_o && out_data_o.result_kind == KindLineEnd, out_data_o.last_of_run, "line end not final result")
  `DLT_ASSERT_NEXT(a_tok_end_pair, out_fire && out_data_o.result_kind == KindTokEnd && !out_data_o.last_of_run, out_valid_o && out_data_o.result_kind == KindLineEnd, "token end not followed by line end")

endmodule

bind delimited_line_tokenizer dlt_checker u_dlt_checker (.*);
